// ===== src/cubic_segment_trajectory_macros.svh =====
// ----------------------------------------------------------------------------
// cubic_segment_trajectory_macros
// Assertion macros used by the cubic segment trajectory module.
// ----------------------------------------------------------------------------
`ifndef CUBIC_SEGMENT_TRAJECTORY_MACROS_SVH
`define CUBIC_SEGMENT_TRAJECTORY_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define CST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define CST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and fixed constants of the cubic segment trajectory block.
// ----------------------------------------------------------------------------
`default_nettype none
package cst_pkg;
  localparam int unsigned CoefW = 48;
  localparam logic [0:0] ModeLoad = 1'b0;
  localparam logic [0:0] ModeTick = 1'b1;
  localparam logic [0:0] KindStatus = 1'b0;
  localparam logic [0:0] KindSample = 1'b1;

  typedef struct packed {
    logic [0:0]   mode;
    logic [5:0]   duration;
    logic signed [31:0] start_position;
    logic signed [31:0] end_position;
    logic signed [31:0] start_speed;
    logic signed [31:0] end_speed;
  } in_item_t;

  typedef struct packed {
    logic [0:0]   kind;
    logic         accepted;
    logic [8:0]   sample_index;
    logic signed [31:0] position;
    logic signed [31:0] speed;
    logic signed [31:0] accel;
    logic         last;
  } out_item_t;
endpackage
`default_nettype wire

// ===== src/cst_stream_if.sv =====
// ----------------------------------------------------------------------------
// cst_stream_if
// Valid/ready channel carrying one packed payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface cst_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/cst_divider.sv =====
// ----------------------------------------------------------------------------
// cst_divider
// Restoring divider, one quotient bit per cycle, round half away from zero.
// ----------------------------------------------------------------------------
`default_nettype none
module cst_divider (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic signed [63:0] num,
  input  wire logic [23:0] den,
  output logic             done,
  output logic signed [47:0] quo
);
  logic [63:0] n_r, n_nxt;
  logic [63:0] q_r, q_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [23:0] d_r;
  logic        neg_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic [64:0] trial;
  logic [63:0] mag_q;

  always_comb begin
    trial   = {rem_r[63:0], n_r[63]} - {41'd0, d_r};
    n_nxt   = {n_r[62:0], 1'b0};
    rem_nxt = trial[64] ? {rem_r[63:0], n_r[63]} : trial;
    q_nxt   = {q_r[62:0], ~trial[64]};
    mag_q   = q_r;
  end

  // Saturate the magnitude then apply the sign.
  always_comb begin
    logic [63:0] lim;
    lim = neg_r ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
    if (mag_q > lim) quo = neg_r ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    else quo = neg_r ? 48'(-mag_q) : 48'(mag_q);
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 7'd64;
      neg_r  <= num[63];
      n_r    <= (num[63] ? 64'(-num) : 64'(num)) + 64'({1'b0, den[23:1]});
      d_r    <= den;
      rem_r  <= '0;
      q_r    <= '0;
    end else if (busy_r) begin
      n_r   <= n_nxt;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_r <= 1'b0;
        done   <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/cubic_segment_trajectory.sv =====
// ----------------------------------------------------------------------------
// cubic_segment_trajectory
// One-joint cubic segment generator with a shared multiplier and divider.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_ch. A load item (mode 0) checks the duration and,
// if it lies in 1..MAX_DURATION, computes the four cubic coefficients; it
// always returns one status transfer on out_ch. A tick item (mode 1) returns
// the next sample (position, speed, accel at time k/STEPS_PER_UNIT) while a
// segment runs, and nothing while idle. The last sample carries last = 1.
// An accepted load offers its status once the bit-serial divider has run
// twice (division by T^2, then by T^3). A rejected load offers its status
// in the cycle after the input transfer. A tick works through a setup state,
// six products on the one 48-bit by t-width multiplier (each with operand
// fetch, multiply, round and saturating add) and a state that presents the
// sample. The block takes no new item before it is through with the last:
// in_ready is low while an item is worked on and while a result waits; a
// stalled receiver holds the result and blocks the input.
// Reset (rst_n low, synchronous) clears the coefficients, the step counter
// and the running flag; the block comes up idle and ready.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cubic_segment_trajectory_macros.svh"
module cubic_segment_trajectory #(
  parameter int unsigned MAX_DURATION   = 50,
  parameter int unsigned STEPS_PER_UNIT = 10,
  parameter int unsigned FRAC_BITS      = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  cst_stream_if.sink   in_ch,
  cst_stream_if.source out_ch
);
  localparam int W = cst_pkg::CoefW;
  localparam logic signed [W-1:0] MaxV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MinV = {1'b1, {(W-1){1'b0}}};
  // Sample time never exceeds MAX_DURATION in whole units.
  localparam int TW = $clog2(MAX_DURATION + 1) + FRAC_BITS;
  // One step advances the scaled time by 2^FRAC_BITS / STEPS_PER_UNIT.
  localparam int unsigned TqStep = (32'd1 << FRAC_BITS) / STEPS_PER_UNIT;
  localparam int unsigned TrStep = (32'd1 << FRAC_BITS) % STEPS_PER_UNIT;

  typedef enum logic [3:0] {
    S_IDLE, S_LD_N, S_DIV2, S_DIV3, S_TK_T, S_MUL_A, S_MUL_B, S_ACC, S_OUT
  } state_t;

  state_t state_r;
  logic signed [W-1:0] c0_r, c1_r, c2_r, c3_r;
  logic [8:0] step_r, final_r;
  logic       run_r;
  cst_pkg::in_item_t  item_r;
  cst_pkg::out_item_t out_r;
  logic               out_v_r;
  logic signed [63:0] n2_r, n3_r;
  logic [23:0]        den_r;
  logic               div_start_r;
  logic               div_done;
  logic signed [W-1:0] div_q;
  logic [2:0]          op_r;
  logic signed [W-1:0] t_r, h_r, a_r, acc_r, pos_r, spd_r;
  logic [4:0]          trem_r;
  logic [4:0]          trem_sum;
  logic [TW+W-1:0]     prod_r;
  logic                neg_r;

  cst_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start_r), .num(n2_r),
    .den(den_r), .done(div_done), .quo(div_q)
  );

  function automatic logic signed [W-1:0] sat(input logic signed [W+3:0] x);
    if (x > (W+4)'(MaxV)) return MaxV;
    if (x < (W+4)'(MinV)) return MinV;
    return W'(x);
  endfunction

  function automatic logic signed [31:0] o32(input logic signed [W-1:0] x);
    if (x > W'(64'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (x < W'(-64'sh8000_0000)) return 32'sh8000_0000;
    return 32'(x);
  endfunction

  // Per-op operand selection for the six Horner steps.
  logic signed [W-1:0] c2x2, c3x3, c3x6, mul_b, add_c;
  always_comb begin
    c2x2 = sat((W+4)'(c2_r) <<< 1);
    c3x3 = sat((W+4)'(c3_r) * 3);
    c3x6 = sat((W+4)'(c3_r) * 6);
    unique case (op_r)
      3'd0: begin mul_b = c3_r; add_c = c2_r; end
      3'd1: begin mul_b = h_r;  add_c = c1_r; end
      3'd2: begin mul_b = h_r;  add_c = c0_r; end
      3'd3: begin mul_b = c3x3; add_c = c2x2; end
      3'd4: begin mul_b = h_r;  add_c = c1_r; end
      default: begin mul_b = c3x6; add_c = c2x2; end
    endcase
  end

  // Rounded, saturated product of t and |b|, with the sign of b applied.
  logic signed [W-1:0] prod_q;
  always_comb begin
    logic [95:0] r;
    logic [95:0] lim;
    r   = 96'(prod_r) + (96'd1 << (FRAC_BITS - 1));
    r   = r >> FRAC_BITS;
    lim = neg_r ? 96'h8000_0000_0000 : 96'h7FFF_FFFF_FFFF;
    if (r > lim) r = lim;
    prod_q = neg_r ? W'(-r) : W'(r);
  end

  logic [W-1:0] mag_a;
  assign mag_a = a_r[W-1] ? W'(-a_r) : W'(a_r);

  // Remainder of the running time division after one more step.
  assign trem_sum = trem_r + 5'(TrStep);

  assign in_ch.ready = (state_r == S_IDLE) && !out_v_r;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  always_ff @(posedge clk) begin
    div_start_r <= 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      c0_r <= '0; c1_r <= '0; c2_r <= '0; c3_r <= '0;
      step_r <= '0; final_r <= '0; run_r <= 1'b0; out_v_r <= 1'b0;
    end else begin
      if (out_v_r && out_ch.ready) out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            item_r <= in_ch.data;
            if (in_ch.data.mode == cst_pkg::ModeLoad) begin
              run_r <= 1'b0;
              out_r <= '0;
              out_r.kind <= cst_pkg::KindStatus;
              if (in_ch.data.duration == 6'd0 ||
                  32'(in_ch.data.duration) > MAX_DURATION) begin
                out_v_r <= 1'b1;
              end else begin
                state_r <= S_LD_N;
              end
            end else if (run_r) begin
              state_r <= S_TK_T;
            end
          end
        end
        S_LD_N: begin
          logic signed [63:0] d, diff;
          d    = 64'(item_r.duration);
          diff = 64'(item_r.end_position) - 64'(item_r.start_position);
          // Narrow multiplies by a 6-bit duration.
          n2_r <= 3 * diff - (2 * 64'(item_r.start_speed) + 64'(item_r.end_speed)) * d;
          n3_r <= -2 * diff + (64'(item_r.start_speed) + 64'(item_r.end_speed)) * d;
          den_r <= 24'(d * d);
          div_start_r <= 1'b1;
          state_r <= S_DIV2;
        end
        S_DIV2: begin
          if (div_done) begin
            c2_r  <= div_q;
            n2_r  <= n3_r;
            den_r <= 24'(32'(den_r) * 32'(item_r.duration));
            div_start_r <= 1'b1;
            state_r <= S_DIV3;
          end
        end
        S_DIV3: begin
          if (div_done) begin
            c3_r <= div_q;
            c0_r <= W'(item_r.start_position);
            c1_r <= W'(item_r.start_speed);
            step_r  <= '0;
            t_r     <= '0;
            trem_r  <= 5'(STEPS_PER_UNIT / 2);
            final_r <= 9'(32'(item_r.duration) * STEPS_PER_UNIT);
            run_r   <= 1'b1;
            out_r.accepted <= 1'b1;
            out_v_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_TK_T: begin
          // t_r already holds the rounded sample time of this step.
          op_r <= 3'd0;
          state_r <= S_MUL_A;
        end
        S_MUL_A: begin
          a_r   <= mul_b;
          acc_r <= add_c;
          state_r <= S_MUL_B;
        end
        S_MUL_B: begin
          neg_r  <= a_r[W-1];
          prod_r <= t_r[TW-1:0] * mag_a;
          state_r <= S_ACC;
        end
        S_ACC: begin
          logic signed [W-1:0] s;
          s = sat((W+4)'(acc_r) + (W+4)'(prod_q));
          h_r <= s;
          if (op_r == 3'd2) pos_r <= s;
          if (op_r == 3'd4) spd_r <= s;
          if (op_r == 3'd5) begin
            out_r.kind <= cst_pkg::KindSample;
            out_r.accepted <= 1'b0;
            out_r.sample_index <= step_r;
            out_r.position <= o32(pos_r);
            out_r.speed <= o32(spd_r);
            out_r.accel <= o32(s);
            out_r.last <= (step_r == final_r);
            state_r <= S_OUT;
          end else begin
            op_r <= op_r + 3'd1;
            state_r <= S_MUL_A;
          end
        end
        S_OUT: begin
          out_v_r <= 1'b1;
          if (step_r == final_r) begin
            run_r <= 1'b0;
          end else begin
            step_r <= step_r + 9'd1;
            // Keep t = round(k * 2^FRAC_BITS / STEPS_PER_UNIT) as a running
            // quotient and remainder, so no divider is needed per tick.
            if (trem_sum >= 5'(STEPS_PER_UNIT)) begin
              trem_r <= trem_sum - 5'(STEPS_PER_UNIT);
              t_r    <= t_r + W'(TqStep) + W'(1);
            end else begin
              trem_r <= trem_sum;
              t_r    <= t_r + W'(TqStep);
            end
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `CST_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_r != S_IDLE, !in_ch.ready)
  `CST_ASSERT_NEXT(a_hold_out, clk, rst_n, out_v_r && !out_ch.ready, out_v_r)
  `CST_ASSERT_IMPL(a_step_bound, clk, rst_n, run_r, step_r <= final_r)
endmodule
`default_nettype wire

// ===== verif/tb_cubic_segment_trajectory.sv =====
// ----------------------------------------------------------------------------
// tb_cubic_segment_trajectory
// Self-checking testbench for the cubic segment trajectory block.
// ----------------------------------------------------------------------------
// Segment loads and sample ticks go in on in_ch. A built-in predictor keeps
// its own copy of the coefficients and the step counter and works out each
// status and each sample bit for bit. A checker compares every output
// transfer with the oldest predicted result. Directed tests cover the
// duration limits, the extreme field values, a run to the last sample, ticks
// while idle and a load that restarts a running segment. Random segments
// follow under several idle and stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_cubic_segment_trajectory;

  localparam int unsigned MaxDuration  = 50;
  localparam int unsigned StepsPerUnit = 10;
  localparam int unsigned FracBits     = 16;
  localparam longint      Max48        = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      Min48        = -Max48 - 1;
  // The watchdog limit must cover a load, also one whose output stalls.
  localparam int          StallLimit   = 20000;
  localparam int          DrainCycles  = 300;

  logic clk;
  logic rst_n;

  cst_stream_if #(.payload_t(cst_pkg::in_item_t))  in_ch ();
  cst_stream_if #(.payload_t(cst_pkg::out_item_t)) out_ch ();

  cubic_segment_trajectory dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: a private copy of what the block holds.
  longint seg_c0, seg_c1, seg_c2, seg_c3;
  int     seg_step, seg_final;
  bit     seg_active;

  cst_pkg::out_item_t pending_results[$];

  int error_count;
  int idle_pct;
  int stall_pct;
  int idle_cycles;
  int load_count, reject_count, sample_count, last_count, idle_tick_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Fixed-point helpers of the predictor.
  // -------------------------------------------------------------------------
  function automatic longint sat48(longint x);
    if (x > Max48) return Max48;
    if (x < Min48) return Min48;
    return x;
  endfunction

  // Division rounded to nearest with ties away from zero, then saturated.
  function automatic longint div_round(longint n, longint d);
    logic [63:0] m;
    logic [63:0] q;
    m = (n < 0) ? -n : n;
    q = (m + d / 2) / d;
    return sat48((n < 0) ? -longint'(q) : longint'(q));
  endfunction

  // Fractional product, rounded ties away from zero and saturated to 48 bits.
  function automatic longint mul_frac(longint a, longint b);
    logic          neg;
    logic [127:0]  p;
    logic [127:0]  lim;
    neg = (a < 0) != (b < 0);
    p = 128'((a < 0) ? -a : a) * 128'((b < 0) ? -b : b);
    p = (p + (128'd1 << (FracBits - 1))) >> FracBits;
    lim = neg ? 128'(Max48) + 128'd1 : 128'(Max48);
    if (p > lim) p = lim;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  // Update the predictor state for one accepted item and queue its result.
  task automatic predict_trajectory(input cst_pkg::in_item_t it);
    cst_pkg::out_item_t res;
    longint    dur, diff, n2, n3, t, c2x2, c3x3, c3x6, h, pos, spd, acc;
    res = '0;
    if (it.mode == cst_pkg::ModeLoad) begin
      dur = longint'(it.duration);
      seg_active = 1'b0;
      res.kind = cst_pkg::KindStatus;
      load_count++;
      if (dur == 0 || dur > MaxDuration) begin
        reject_count++;
      end else begin
        diff = longint'(it.end_position) - longint'(it.start_position);
        n2 = 3 * diff - (2 * longint'(it.start_speed) + longint'(it.end_speed)) * dur;
        n3 = -2 * diff + (longint'(it.start_speed) + longint'(it.end_speed)) * dur;
        seg_c0 = longint'(it.start_position);
        seg_c1 = longint'(it.start_speed);
        seg_c2 = div_round(n2, dur * dur);
        seg_c3 = div_round(n3, dur * dur * dur);
        seg_step = 0;
        seg_final = int'(dur) * StepsPerUnit;
        seg_active = 1'b1;
        res.accepted = 1'b1;
      end
      pending_results.push_back(res);
    end else if (!seg_active) begin
      // A tick with no running segment produces nothing.
      idle_tick_count++;
    end else begin
      t = ((longint'(seg_step) << FracBits) + StepsPerUnit / 2) / StepsPerUnit;
      c2x2 = sat48(2 * seg_c2);
      c3x3 = sat48(3 * seg_c3);
      c3x6 = sat48(6 * seg_c3);
      h = sat48(seg_c2 + mul_frac(t, seg_c3));
      h = sat48(seg_c1 + mul_frac(t, h));
      pos = sat48(seg_c0 + mul_frac(t, h));
      h = sat48(c2x2 + mul_frac(t, c3x3));
      spd = sat48(seg_c1 + mul_frac(t, h));
      acc = sat48(c2x2 + mul_frac(t, c3x6));
      res.kind = cst_pkg::KindSample;
      res.sample_index = seg_step[8:0];
      res.position = clamp32(pos);
      res.speed = clamp32(spd);
      res.accel = clamp32(acc);
      res.last = (seg_step == seg_final);
      sample_count++;
      if (res.last) begin
        last_count++;
        seg_active = 1'b0;
      end else begin
        seg_step++;
      end
      pending_results.push_back(res);
    end
  endtask

  // -------------------------------------------------------------------------
  // Sender side. One call moves one item; valid stays high across
  // back-to-back transfers and drops only for a drawn idle gap or at the end of a random run.
  // -------------------------------------------------------------------------
  task automatic send_item(input cst_pkg::in_item_t it);
    int gap;
    gap = 0;
    if (idle_pct > 0) begin
      while ($urandom_range(0, 99) < idle_pct && gap < 12) gap++;
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    predict_trajectory(it);
  endtask

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 6))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'(signed'($urandom_range(0, 200 << FracBits)) - (100 << FracBits));
      3: return 32'(signed'($urandom_range(0, 20 << FracBits)) - (10 << FracBits));
      default: return $urandom;
    endcase
  endfunction

  function automatic cst_pkg::in_item_t make_load(input logic [5:0] dur);
    cst_pkg::in_item_t it;
    it.mode = cst_pkg::ModeLoad;
    it.duration = dur;
    it.start_position = pick_word();
    it.end_position = pick_word();
    it.start_speed = pick_word();
    it.end_speed = pick_word();
    return it;
  endfunction

  // Tick payloads carry random junk in the unused fields; the block must
  // ignore it.
  function automatic cst_pkg::in_item_t make_tick();
    cst_pkg::in_item_t it;
    it.mode = cst_pkg::ModeTick;
    it.duration = 6'($urandom);
    it.start_position = $urandom;
    it.end_position = $urandom;
    it.start_speed = $urandom;
    it.end_speed = $urandom;
    return it;
  endfunction

  task automatic send_ticks(input int n);
    repeat (n) send_item(make_tick());
  endtask

  // -------------------------------------------------------------------------
  // Receiver side: random stalls and the result checker.
  // -------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk) begin
    cst_pkg::out_item_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result kind", got.kind, -1);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
        if (got.accepted !== want.accepted)
          report_mismatch("accepted", got.accepted, want.accepted);
        if (got.sample_index !== want.sample_index)
          report_mismatch("sample_index", got.sample_index, want.sample_index);
        if (got.position !== want.position)
          report_mismatch("position", got.position, want.position);
        if (got.speed !== want.speed) report_mismatch("speed", got.speed, want.speed);
        if (got.accel !== want.accel) report_mismatch("accel", got.accel, want.accel);
        if (got.last !== want.last) report_mismatch("last", got.last, want.last);
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: a long stretch with no transfer on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no transfer for %0d cycles", StallLimit);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Tests.
  // -------------------------------------------------------------------------
  task automatic test_idle_tick();
    send_ticks(1);                        // tick while idle after reset
  endtask

  task automatic test_duration_limits();
    send_item(make_load(6'd0));           // zero duration is rejected
    send_item(make_load(6'd63));          // all-ones duration is rejected
    send_item(make_load(6'd51));          // just above the limit
    send_ticks(1);                        // still idle after a reject
  endtask

  task automatic test_extreme_values();
    cst_pkg::in_item_t it;
    it = make_load(6'd1);
    it.start_position = 32'sh8000_0000;
    it.end_position = 32'sh7FFF_FFFF;
    it.start_speed = 32'sh7FFF_FFFF;
    it.end_speed = 32'sh7FFF_FFFF;
    send_item(it);
    send_ticks(12);                       // full run, last sample, one idle tick
    it.start_position = 32'sh7FFF_FFFF;
    it.end_position = 32'sh8000_0000;
    it.start_speed = 32'sh8000_0000;
    it.end_speed = 32'sh8000_0000;
    send_item(it);
    send_ticks(3);
  endtask

  task automatic test_restart();
    send_item(make_load(6'd50));          // longest segment, restarts the run
    send_ticks(3);
  endtask

  // Well-formed segments with random content make up most of the traffic;
  // rejected loads, aborted runs and stray ticks are mixed in.
  task automatic run_random_segments(input int items, input int sender_idle,
                                     input int receiver_stall);
    int sent, dur, n;
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 19))
        0: dur = 0;
        1: dur = $urandom_range(MaxDuration + 1, 63);
        2: dur = $urandom_range(5, MaxDuration);
        default: dur = $urandom_range(1, 3);
      endcase
      send_item(make_load(6'(dur)));
      sent++;
      if (dur >= 1 && dur <= MaxDuration) begin
        n = dur * StepsPerUnit + 1;
        if (dur > 4) n = $urandom_range(1, 20);
        else if ($urandom_range(0, 5) == 0) n = $urandom_range(0, n);
        else n += $urandom_range(0, 2);
      end else begin
        n = $urandom_range(0, 2);
      end
      send_ticks(n);
      sent += n;
    end
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    error_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    load_count = 0;
    reject_count = 0;
    sample_count = 0;
    last_count = 0;
    idle_tick_count = 0;
    seg_c0 = 0;
    seg_c1 = 0;
    seg_c2 = 0;
    seg_c3 = 0;
    seg_step = 0;
    seg_final = 0;
    seg_active = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_tick();
    test_duration_limits();
    test_extreme_values();
    test_restart();
    run_random_segments(500, 0, 0);
    run_random_segments(500, 74, 0);
    run_random_segments(500, 0, 74);
    run_random_segments(500, 36, 36);

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Covered %0d loads (%0d rejected), %0d samples, %0d segment ends,",
             load_count, reject_count, sample_count, last_count);
    $display("and %0d idle ticks over four idle/stall mixes.", idle_tick_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
